### design/assert_macros.svh
// assertion macros shared by the classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhcw same-cycle check failed");
`define RHCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhcw next-cycle check failed");
`else
`define RHCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RHCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/rhcw_pkg.sv
// types, constants and codes of the rgb to hsv color window classifier
package rhcw_pkg;

  localparam int CH_W    = 8;
  localparam int HUE_W   = 16;
  localparam int SAT_W   = 9;
  localparam int HCFG_W  = 9;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;

  localparam int HUE_FRAC   = 6;
  localparam int SAT_SHIFT  = 8;
  localparam int SECT_HI    = 12;
  localparam int SECT_LO    = 8;

  localparam logic signed [HUE_W-1:0] HUE_SECTOR = 16'sd3840;
  localparam logic signed [HUE_W-1:0] HUE_FULL   = 16'sd23040;
  localparam logic signed [HUE_W-1:0] HUE_UNDEF  = -16'sd64;

  localparam logic [HCFG_W-1:0] HUE_LOW_RST  = 9'd60;
  localparam logic [HCFG_W-1:0] HUE_HIGH_RST = 9'd150;
  localparam logic [SAT_W-1:0]  SAT_MIN_RST  = 9'd77;
  localparam logic [CH_W-1:0]   VAL_MIN_RST  = 8'd102;

  // divider: quotient bits, dividend width, quotient bits per stage
  localparam int DIV_QW     = 12;
  localparam int DIV_NW     = 20;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_QW / DIV_STEPS;

  // front stage, divider stages, hue assembly, output register
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_HUE_LOW  = 2'd0,
    CFG_HUE_HIGH = 2'd1,
    CFG_SAT_MIN  = 2'd2,
    CFG_VAL_MIN  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_REJECT  = 2'd0,
    VERDICT_KEEP    = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            pv;
    logic [CH_W-1:0] mx;
    logic            dnz;
    sector_t         sec;
    logic            neg;
  } side_t;

  typedef struct packed {
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
    logic                    pv;
    logic                    dnz;
    logic signed [HUE_W-1:0] hue;
    logic [SAT_W-1:0]        sat;
    logic [CH_W-1:0]         bright;
  } hsv_t;

endpackage

### design/rhcw_div.sv
// pipelined restoring divider, a few quotient bits per stage
module rhcw_div (
  input  logic                          clk,
  input  logic [rhcw_pkg::DIV_STAGES-1:0] adv,
  input  logic [rhcw_pkg::DIV_NW-1:0]   dividend,
  input  logic [rhcw_pkg::CH_W-1:0]     divisor,
  output logic [rhcw_pkg::DIV_QW-1:0]   quotient,
  output logic                          rem_nz
);

  localparam int NW     = rhcw_pkg::DIV_NW;
  localparam int QW     = rhcw_pkg::DIV_QW;
  localparam int STEPS  = rhcw_pkg::DIV_STEPS;
  localparam int STAGES = rhcw_pkg::DIV_STAGES;
  localparam int DW     = rhcw_pkg::CH_W;

  logic [NW-1:0] rem_r [STAGES];
  logic [QW-1:0] quo_r [STAGES];
  logic [DW-1:0] dvs_r [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] dvs_in;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in = dividend;
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign dvs_in = dvs_r[j-1];
    end

    always_comb begin
      logic [NW-1:0] trial;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int s = 0; s < STEPS; s++) begin
        trial = NW'(dvs_in) << (QW - 1 - (j * STEPS + s));
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          quo_nxt = {quo_nxt[QW-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        dvs_r[j] <= dvs_in;
      end
    end
  end

  assign quotient = quo_r[STAGES-1];
  assign rem_nz   = |rem_r[STAGES-1];

endmodule

### design/rgb_hsv_color_window_classifier.sv
// top level of the rgb to hsv color window classifier
//
// Pixels enter on the in_ channel (in_valid / in_stall) with red, green, blue
// and a point-valid flag, one per clock while in_stall is low. Each pixel is
// converted to hue in 1/64 degree, saturation (256 = 1.0) and value, and is
// kept when its hue lies in [hue_low, hue_high] degrees and saturation and
// value reach their minimums; rejected pixels leave as black, invalid points
// pass unchanged. Results leave on the out_ channel (out_valid / out_stall)
// in input order. Throughput is one pixel per cycle while out_stall is low,
// set by two six-stage restoring dividers (two quotient bits per stage) for
// hue and saturation that run side by side. Each stage moves on when it is
// empty or the stage after it moves, so bubbles close up and a stalled output
// stops only the stages behind it; in_stall rises once all nine stages hold
// pixels and out_stall is high. Registers are written by the user on the cfg_
// channel (cfg_valid / cfg_ready, always ready) only while the pipeline is
// empty; the block does not enforce it. Synchronous reset empties the
// pipeline and loads the window 60..150 deg, saturation 77, value 102.
`include "assert_macros.svh"

module rgb_hsv_color_window_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rhcw_pkg::CH_W-1:0]         in_red,
  input  logic [rhcw_pkg::CH_W-1:0]         in_green,
  input  logic [rhcw_pkg::CH_W-1:0]         in_blue,
  input  logic                              in_point_valid,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_verdict,
  output logic [rhcw_pkg::CH_W-1:0]         out_red,
  output logic [rhcw_pkg::CH_W-1:0]         out_green,
  output logic [rhcw_pkg::CH_W-1:0]         out_blue,
  output logic signed [rhcw_pkg::HUE_W-1:0] out_hue,
  output logic [rhcw_pkg::SAT_W-1:0]        out_saturation,
  output logic [rhcw_pkg::CH_W-1:0]         out_brightness,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rhcw_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [rhcw_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int NST   = rhcw_pkg::PIPE_STAGES;
  localparam int DS    = rhcw_pkg::DIV_STAGES;
  localparam int CW    = rhcw_pkg::CH_W;
  localparam int HW    = rhcw_pkg::HUE_W;
  localparam int SW    = rhcw_pkg::SAT_W;
  localparam int NW    = rhcw_pkg::DIV_NW;
  localparam int QW    = rhcw_pkg::DIV_QW;

  // configuration registers
  logic [rhcw_pkg::HCFG_W-1:0] hue_low_r;
  logic [rhcw_pkg::HCFG_W-1:0] hue_high_r;
  logic [SW-1:0]               sat_min_r;
  logic [CW-1:0]               val_min_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= rhcw_pkg::HUE_LOW_RST;
      hue_high_r <= rhcw_pkg::HUE_HIGH_RST;
      sat_min_r  <= rhcw_pkg::SAT_MIN_RST;
      val_min_r  <= rhcw_pkg::VAL_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rhcw_pkg::cfg_idx_t'(cfg_index))
        rhcw_pkg::CFG_HUE_LOW:  hue_low_r  <= cfg_wdata;
        rhcw_pkg::CFG_HUE_HIGH: hue_high_r <= cfg_wdata;
        rhcw_pkg::CFG_SAT_MIN:  sat_min_r  <= cfg_wdata;
        rhcw_pkg::CFG_VAL_MIN:  val_min_r  <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NST-1];

  // front stage: max, min, sector and hue numerator
  logic [CW-1:0]     mx_c;
  logic [CW-1:0]     mn_c;
  logic [CW-1:0]     x_c;
  logic [CW-1:0]     y_c;
  logic [CW-1:0]     mag_c;
  logic              neg_c;
  rhcw_pkg::sector_t sec_c;
  rhcw_pkg::side_t   side0_nxt;

  always_comb begin
    mx_c = in_red;
    if (in_green > mx_c) begin
      mx_c = in_green;
    end
    if (in_blue > mx_c) begin
      mx_c = in_blue;
    end
    mn_c = in_red;
    if (in_green < mn_c) begin
      mn_c = in_green;
    end
    if (in_blue < mn_c) begin
      mn_c = in_blue;
    end
    if (in_red == mx_c) begin
      sec_c = rhcw_pkg::SEC_RED;
      x_c   = in_green;
      y_c   = in_blue;
    end else if (in_green == mx_c) begin
      sec_c = rhcw_pkg::SEC_GREEN;
      x_c   = in_blue;
      y_c   = in_red;
    end else begin
      sec_c = rhcw_pkg::SEC_BLUE;
      x_c   = in_red;
      y_c   = in_green;
    end
    neg_c = x_c < y_c;
    mag_c = neg_c ? (y_c - x_c) : (x_c - y_c);
  end

  always_comb begin
    side0_nxt.red   = in_red;
    side0_nxt.green = in_green;
    side0_nxt.blue  = in_blue;
    side0_nxt.pv    = in_point_valid;
    side0_nxt.mx    = mx_c;
    side0_nxt.dnz   = mx_c != mn_c;
    side0_nxt.sec   = sec_c;
    side0_nxt.neg   = neg_c;
  end

  rhcw_pkg::side_t side_r [DS+1];
  logic [CW-1:0]   mag0_r;
  logic [CW-1:0]   delta0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side0_nxt;
      mag0_r    <= mag_c;
      delta0_r  <= mx_c - mn_c;
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // dividers: 3840 * mag / delta and 256 * delta / max
  logic [NW-1:0] hue_dvd;
  logic [NW-1:0] sat_dvd;
  logic [QW-1:0] hue_q;
  logic          hue_rnz;
  logic [QW-1:0] sat_q;

  assign hue_dvd = (NW'(mag0_r) << rhcw_pkg::SECT_HI) - (NW'(mag0_r) << rhcw_pkg::SECT_LO);
  assign sat_dvd = NW'(delta0_r) << rhcw_pkg::SAT_SHIFT;

  rhcw_div u_hue_div (
    .clk      (clk),
    .adv      (en[DS:1]),
    .dividend (hue_dvd),
    .divisor  (delta0_r),
    .quotient (hue_q),
    .rem_nz   (hue_rnz)
  );

  rhcw_div u_sat_div (
    .clk      (clk),
    .adv      (en[DS:1]),
    .dividend (sat_dvd),
    .divisor  (side_r[0].mx),
    .quotient (sat_q),
    .rem_nz   ()
  );

  // hue assembly
  rhcw_pkg::side_t     sd;
  logic signed [HW-1:0] base_c;
  logic signed [HW-1:0] qpos_c;
  logic signed [HW-1:0] qneg_c;
  logic signed [HW-1:0] hraw_c;
  logic                 def_c;
  rhcw_pkg::hsv_t       hs_nxt;
  rhcw_pkg::hsv_t       hs_r;

  assign sd = side_r[DS];

  always_comb begin
    case (sd.sec)
      rhcw_pkg::SEC_RED:   base_c = '0;
      rhcw_pkg::SEC_GREEN: base_c = HW'(rhcw_pkg::HUE_SECTOR <<< 1);
      rhcw_pkg::SEC_BLUE:  base_c = HW'(rhcw_pkg::HUE_SECTOR <<< 2);
      default:             base_c = '0;
    endcase
    qpos_c = signed'(HW'(hue_q));
    // floor of a negative quotient rounds away from zero
    qneg_c = signed'(HW'(hue_q) + HW'(hue_rnz));
    hraw_c = sd.neg ? (base_c - qneg_c) : (base_c + qpos_c);
    if (hraw_c < 0) begin
      hraw_c = hraw_c + rhcw_pkg::HUE_FULL;
    end
    def_c = sd.pv && sd.dnz;

    hs_nxt.red    = sd.red;
    hs_nxt.green  = sd.green;
    hs_nxt.blue   = sd.blue;
    hs_nxt.pv     = sd.pv;
    hs_nxt.dnz    = sd.dnz;
    hs_nxt.hue    = def_c ? hraw_c : rhcw_pkg::HUE_UNDEF;
    hs_nxt.sat    = def_c ? sat_q[SW-1:0] : '0;
    hs_nxt.bright = sd.pv ? sd.mx : '0;
  end

  always_ff @(posedge clk) begin
    if (en[DS+1]) begin
      hs_r <= hs_nxt;
    end
  end

  // window test and masking
  logic [HW-1:0]        hue_u;
  logic [HW-1:0]        lo_c;
  logic [HW-1:0]        hi_c;
  logic                 keep_c;
  rhcw_pkg::verdict_t   verdict_c;
  logic                 pass_c;

  logic [1:0]           verdict_r;
  logic [CW-1:0]        red_r;
  logic [CW-1:0]        green_r;
  logic [CW-1:0]        blue_r;
  logic signed [HW-1:0] hue_r;
  logic [SW-1:0]        sat_r;
  logic [CW-1:0]        bright_r;

  always_comb begin
    hue_u  = unsigned'(hs_r.hue);
    lo_c   = HW'(hue_low_r) << rhcw_pkg::HUE_FRAC;
    hi_c   = HW'(hue_high_r) << rhcw_pkg::HUE_FRAC;
    keep_c = hs_r.pv && hs_r.dnz && (hue_u >= lo_c) && (hue_u <= hi_c)
             && (hs_r.sat >= sat_min_r) && (hs_r.bright >= val_min_r);
    if (!hs_r.pv) begin
      verdict_c = rhcw_pkg::VERDICT_INVALID;
    end else if (keep_c) begin
      verdict_c = rhcw_pkg::VERDICT_KEEP;
    end else begin
      verdict_c = rhcw_pkg::VERDICT_REJECT;
    end
    pass_c = !hs_r.pv || keep_c;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      verdict_r <= verdict_c;
      red_r     <= pass_c ? hs_r.red : '0;
      green_r   <= pass_c ? hs_r.green : '0;
      blue_r    <= pass_c ? hs_r.blue : '0;
      hue_r     <= hs_r.hue;
      sat_r     <= hs_r.sat;
      bright_r  <= hs_r.bright;
    end
  end

  assign out_verdict    = verdict_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

  `RHCW_ASSERT_IMP(a_keep_hue_def, clk, rst_n, out_valid && out_verdict == rhcw_pkg::VERDICT_KEEP, out_hue != rhcw_pkg::HUE_UNDEF)
  `RHCW_ASSERT_IMP(a_reject_black, clk, rst_n, out_valid && out_verdict == rhcw_pkg::VERDICT_REJECT, out_red == '0 && out_green == '0 && out_blue == '0)
  `RHCW_ASSERT_IMP(a_invalid_hsv, clk, rst_n, out_valid && out_verdict == rhcw_pkg::VERDICT_INVALID, out_hue == rhcw_pkg::HUE_UNDEF && out_saturation == '0 && out_brightness == '0)
  `RHCW_ASSERT_IMP(a_empty_ready, clk, rst_n, vld_r == '0, !in_stall)
  `RHCW_ASSERT_NXT(a_accept_load, clk, rst_n, in_valid && !in_stall, vld_r[0])

endmodule

### tb/tb_rgb_hsv_color_window_classifier.sv
// testbench for the rgb to hsv color window classifier with a per-pixel predictor
`timescale 1ns / 1ps

module tb_rgb_hsv_color_window_classifier;
  import rhcw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_IDLE    = 11;
  localparam int unsigned LONG_HOLD   = 80;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            pv;
  } pixel_t;

  typedef struct packed {
    verdict_t                verdict;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
    logic signed [HUE_W-1:0] hue;
    logic [SAT_W-1:0]        sat;
    logic [CH_W-1:0]         bright;
  } hsv_verdict_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CH_W-1:0]         in_red = '0;
  logic [CH_W-1:0]         in_green = '0;
  logic [CH_W-1:0]         in_blue = '0;
  logic                    in_point_valid = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_verdict;
  logic [CH_W-1:0]         out_red;
  logic [CH_W-1:0]         out_green;
  logic [CH_W-1:0]         out_blue;
  logic signed [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0]        out_saturation;
  logic [CH_W-1:0]         out_brightness;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CIDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  logic [HCFG_W-1:0] win_hue_low  = HUE_LOW_RST;
  logic [HCFG_W-1:0] win_hue_high = HUE_HIGH_RST;
  logic [SAT_W-1:0]  win_sat_min  = SAT_MIN_RST;
  logic [CH_W-1:0]   win_val_min  = VAL_MIN_RST;

  hsv_verdict_t expected_hsv_q[$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_count = 0;
  int unsigned stall_cycles = 0;

  bit          tx_no_idle = 1'b0;
  bit          rx_no_idle = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold_cnt = 0;

  rgb_hsv_color_window_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_point_valid (in_point_valid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) stall_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_hsv_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic hsv_verdict_t classify_pixel(input pixel_t px);
    hsv_verdict_t res;
    int r, g, b, mx, mn, delta, num, base, prod, q, hue, sat;
    bit keep;
    r = px.red;
    g = px.green;
    b = px.blue;
    if (!px.pv) begin
      res.verdict = VERDICT_INVALID;
      res.red     = px.red;
      res.green   = px.green;
      res.blue    = px.blue;
      res.hue     = HUE_UNDEF;
      res.sat     = '0;
      res.bright  = '0;
      return res;
    end
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
    sat = (mx > 0) ? (delta * 256) / mx : 0;
    hue = -64;
    if (delta > 0) begin
      if (r == mx) begin
        base = 0;
        num  = g - b;
      end else if (g == mx) begin
        base = 2 * int'(HUE_SECTOR);
        num  = b - r;
      end else begin
        base = 4 * int'(HUE_SECTOR);
        num  = r - g;
      end
      prod = int'(HUE_SECTOR) * num;
      // round toward minus infinity
      q = (prod >= 0) ? prod / delta : -((-prod + delta - 1) / delta);
      hue = base + q;
      if (hue < 0) hue += int'(HUE_FULL);
    end
    keep = (delta > 0) && (hue >= int'(win_hue_low) * 64) && (hue <= int'(win_hue_high) * 64)
        && (sat >= int'(win_sat_min)) && (mx >= int'(win_val_min));
    res.verdict = keep ? VERDICT_KEEP : VERDICT_REJECT;
    res.red     = keep ? px.red : '0;
    res.green   = keep ? px.green : '0;
    res.blue    = keep ? px.blue : '0;
    res.hue     = (delta > 0) ? hue[HUE_W-1:0] : HUE_UNDEF;
    res.sat     = sat[SAT_W-1:0];
    res.bright  = mx[CH_W-1:0];
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    px.red   = CH_W'($urandom);
    px.green = CH_W'($urandom);
    px.blue  = CH_W'($urandom);
    px.pv    = 1'b1;
    if (pick < 8) begin
      px.pv = 1'b0;
    end else if (pick < 14) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (pick < 24) begin
      case ($urandom_range(0, 2))
        0: px.green = px.red;
        1: px.blue = px.green;
        default: px.red = px.blue;
      endcase
    end else if (pick < 32) begin
      case ($urandom_range(0, 2))
        0: begin px.red = 8'd255; px.blue = 8'd0; end
        1: begin px.green = 8'd255; px.red = 8'd0; end
        default: begin px.blue = 8'd255; px.green = 8'd0; end
      endcase
    end
    return px;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  // receiver: random wait after each transfer, plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold_cnt = 0;
    end else begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_cnt = LONG_HOLD;
      end
      if (out_valid && !out_stall) rx_wait = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (rx_hold_cnt > 0) begin
        rx_hold_cnt--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    hsv_verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_hsv_q.size() == 0) begin
        flag_error($sformatf("unexpected result verdict %0d rgb %0d/%0d/%0d", out_verdict,
                             out_red, out_green, out_blue));
      end else begin
        e = expected_hsv_q.pop_front();
        if (out_verdict !== e.verdict || out_red !== e.red || out_green !== e.green
            || out_blue !== e.blue || out_hue !== e.hue || out_saturation !== e.sat
            || out_brightness !== e.bright) begin
          flag_error($sformatf({"expected verdict %0d rgb %0d/%0d/%0d hue %0d sat %0d val %0d,",
                                " got verdict %0d rgb %0d/%0d/%0d hue %0d sat %0d val %0d"},
                               e.verdict, e.red, e.green, e.blue, e.hue, e.sat, e.bright,
                               out_verdict, out_red, out_green, out_blue, out_hue,
                               out_saturation, out_brightness));
        end
      end
    end
  end

  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_red         <= px.red;
    in_green       <= px.green;
    in_blue        <= px.blue;
    in_point_valid <= px.pv;
    do @(posedge clk); while (in_stall);
    expected_hsv_q = {expected_hsv_q, classify_pixel(px)};
    pixels_sent++;
  endtask

  task automatic send_rgb(input int r, input int g, input int b, input bit pv);
    send_pixel(pixel_t'{red: r[7:0], green: g[7:0], blue: b[7:0], pv: pv});
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk);
    repeat (PIPE_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HUE_LOW:  win_hue_low  = data[HCFG_W-1:0];
      CFG_HUE_HIGH: win_hue_high = data[HCFG_W-1:0];
      CFG_SAT_MIN:  win_sat_min  = data[SAT_W-1:0];
      CFG_VAL_MIN:  win_val_min  = data[CH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(input int lo, input int hi, input int smin, input int vmin);
    drain_pipeline();
    write_reg(CFG_HUE_LOW, lo[CFG_W-1:0]);
    write_reg(CFG_HUE_HIGH, hi[CFG_W-1:0]);
    write_reg(CFG_SAT_MIN, smin[CFG_W-1:0]);
    write_reg(CFG_VAL_MIN, vmin[CFG_W-1:0]);
    settings_count++;
  endtask

  task automatic test_reset_window();
    send_rgb(0, 255, 0, 1);
    send_rgb(255, 0, 0, 1);
    send_rgb(0, 0, 255, 1);
    send_rgb(255, 255, 0, 1);
    send_rgb(255, 254, 0, 1);
    send_rgb(0, 255, 255, 1);
    send_rgb(255, 0, 255, 1);
    send_rgb(255, 0, 1, 1);
    send_rgb(0, 0, 0, 1);
    send_rgb(255, 255, 255, 1);
    send_rgb(128, 128, 128, 1);
    send_rgb(255, 255, 255, 0);
    send_rgb(0, 0, 0, 0);
    send_rgb(17, 200, 99, 0);
    send_rgb(200, 180, 180, 1);
    send_rgb(40, 80, 40, 1);
    send_rgb(0, 102, 0, 1);
    send_rgb(0, 101, 0, 1);
    send_rgb(178, 255, 178, 1);
    send_rgb(179, 255, 179, 1);
    send_rgb(0, 200, 100, 1);
    send_rgb(0, 200, 101, 1);
    send_rgb(255, 255, 254, 1);
    send_rgb(1, 0, 0, 1);
  endtask

  task automatic test_window_extremes();
    set_window(0, 360, 0, 0);
    send_rgb(255, 0, 0, 1);
    send_rgb(1, 0, 0, 1);
    send_random(60);
    set_window(200, 100, 0, 0);
    send_random(60);
    set_window(0, 511, 511, 255);
    send_random(60);
    set_window(0, 511, 256, 255);
    send_rgb(0, 255, 0, 1);
    send_rgb(255, 0, 254, 1);
    send_random(60);
    set_window(360, 360, 0, 9'h1ff);
    send_rgb(255, 0, 0, 1);
    send_random(60);
  endtask

  task automatic test_random_windows();
    int lo;
    repeat (4) begin
      lo = $urandom_range(0, 360);
      set_window(lo, $urandom_range(lo, 360), $urandom_range(0, 256), $urandom_range(0, 255));
      send_random(90);
    end
    set_window(HUE_LOW_RST, HUE_HIGH_RST, SAT_MIN_RST, VAL_MIN_RST);
  endtask

  task automatic test_output_backpressure();
    tx_no_idle = 1'b1;
    rx_hold_req = 1'b1;
    send_random(48);
    tx_no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_random(30);
    drain_pipeline();
    send_random(30);
  endtask

  task automatic test_mixed_stream();
    for (int i = 0; i < 6; i++) begin
      tx_no_idle = i[0];
      rx_no_idle = i[1];
      send_random(25);
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_window_extremes();
    test_random_windows();
    test_output_backpressure();
    test_sender_pause();
    test_mixed_stream();
    drain_pipeline();
    $display("%0d pixels sent, %0d results checked, %0d input stall cycles", pixels_sent,
             results_checked, stall_cycles);
    $display("%0d window settings incl. full, inverted, out-of-range and reset windows",
             settings_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### rgb_hsv_color_window_classifier.f
+incdir+design
design/rhcw_pkg.sv
design/rhcw_div.sv
design/rgb_hsv_color_window_classifier.sv
tb/tb_rgb_hsv_color_window_classifier.sv
